FILE: sv/mbg_pkg.sv
// Shared types, codes and constants of the maze backtracker generator.
// No dependencies; imported by mbg_core and maze_backtracker_generator.
package mbg_pkg;

  // default grid limits for the top-level parameters
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // configuration register file
  localparam int CFG_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET   = 6'd32;

  // width used for size compares (holds any size up to 256 plus one)
  localparam int CMP_W = 9;

  // item field widths fixed by the stream format
  localparam int RND_W   = 16;
  localparam int COORD_W = 5;

  localparam logic [3:0] WALL_ALL = 4'hF;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_CARVED = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_TILE   = 2'd2,
    STAT_RANGE  = 2'd3
  } stat_t;

  // wall bit i of a tile belongs to direction i
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TILE,
    ST_NB,
    ST_EVAL,
    ST_TOP,
    ST_WR_CUR,
    ST_WR_NB,
    ST_RESP
  } state_t;

  typedef struct packed {
    req_t               req;
    logic [RND_W-1:0]   rnd;
    logic [COORD_W-1:0] tile_row;
    logic [COORD_W-1:0] tile_col;
  } item_t;

  typedef struct packed {
    stat_t              status;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
    dir_t               carve_dir;
    logic [3:0]         walls;   // up, down, left, right from bit 0
  } result_t;

  // one-hot wall bit of a direction
  function automatic logic [3:0] wall_bit(input dir_t d);
    return 4'b0001 << d;
  endfunction

  // direction pointing back across the same wall
  function automatic dir_t opposite(input dir_t d);
    return dir_t'(d ^ 2'b01);
  endfunction

endpackage

FILE: sv/maze_backtracker_generator.sv
// Maze generator (recursive backtracker): stream front end, size registers, result register.
// Depends on mbg_pkg, mbg_core and mbg_ram.
// Work per request: a tile read does one tile RAM read; a carve step does five reads through
// the one tile RAM read port, a capture, a decide and two writes, and each backtracked cell
// adds a stack-top load, five reads, a capture and a decide. Start sweeps every tile entry,
// one per cycle. One request in flight; reset (rst, synchronous) runs the same sweep.
module maze_backtracker_generator #(
  parameter int MAX_ROWS = mbg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mbg_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // random_value, tile_row, tile_col
  input  logic [1:0]                    s_axis_tuser,  // req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // from_row, from_col, carve_dir,
                                                       // wall_up, wall_down, wall_left, wall_right
  output logic [1:0]                    m_axis_tuser,  // status
  // size registers
  input  logic                          cfg_we,
  input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbg_pkg::CFG_W-1:0]     cfg_data
);

  import mbg_pkg::*;

  localparam int SIZE_R_W = $clog2(MAX_ROWS + 1);
  localparam int SIZE_C_W = $clog2(MAX_COLS + 1);
  localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);

  logic [CFG_W-1:0]    row_count;
  logic [CFG_W-1:0]    column_count;
  logic [CMP_W-1:0]    rows_wide, cols_wide;
  logic [SIZE_R_W-1:0] rows;
  logic [SIZE_C_W-1:0] cols;

  item_t   in_item;
  result_t core_res;
  logic    core_res_valid;
  logic    core_res_ready;
  result_t out_res;
  logic    out_valid;

  // size registers; the user must write them only while the block is idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CFG_SIZE_RESET;
      column_count <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count    <= cfg_data;
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        default:          row_count    <= row_count;
      endcase
    end
  end

  // clamp the sizes into 1..MAX
  always_comb begin
    if (row_count == '0)                  rows_wide = CMP_W'(1);
    else if (CMP_W'(row_count) > MAX_R)   rows_wide = MAX_R;
    else                                  rows_wide = CMP_W'(row_count);
    if (column_count == '0)               cols_wide = CMP_W'(1);
    else if (CMP_W'(column_count) > MAX_C) cols_wide = MAX_C;
    else                                  cols_wide = CMP_W'(column_count);
  end
  assign rows = SIZE_R_W'(rows_wide);
  assign cols = SIZE_C_W'(cols_wide);

  // unpack the request beat
  assign in_item.req      = req_t'(s_axis_tuser);
  assign in_item.rnd      = s_axis_tdata[15:0];
  assign in_item.tile_row = s_axis_tdata[20:16];
  assign in_item.tile_col = s_axis_tdata[25:21];

  mbg_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .SIZE_R_W (SIZE_R_W),
    .SIZE_C_W (SIZE_C_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .rows      (rows),
    .cols      (cols),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // result register: hold the beat until taken; the core keeps working meanwhile
  assign core_res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res_ready) begin
      out_valid <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_ready && core_res_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {out_res.walls, out_res.carve_dir,
                          out_res.from_col, out_res.from_row};

endmodule

FILE: sv/mbg_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; used by mbg_core for the tile walls and the path stack.
module mbg_ram #(
  parameter int DATA_W = 4,
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mbg_core.sv
// Carving engine: sequencer around the tile-wall RAM and the path-stack RAM.
// Depends on mbg_pkg and mbg_ram.
module mbg_core #(
  parameter int MAX_ROWS = mbg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mbg_pkg::DEF_MAX_COLS,
  parameter int SIZE_R_W = $clog2(MAX_ROWS + 1),
  parameter int SIZE_C_W = $clog2(MAX_COLS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbg_pkg::item_t       in_item,
  input  logic [SIZE_R_W-1:0]  rows,
  input  logic [SIZE_C_W-1:0]  cols,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mbg_pkg::result_t     res
);

  import mbg_pkg::*;

  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int TILE_AW    = ROW_W + COL_W;
  localparam int TILE_DEPTH = 1 << TILE_AW;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int STK_AW     = $clog2(CELL_COUNT);
  localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
  localparam logic [2:0] NB_LAST = 3'd5;
  localparam logic [2:0] NB_SELF = 3'd4;

  state_t               state, state_next;
  logic [TILE_AW-1:0]   clr_addr;
  logic                 clr_start;
  logic [DEPTH_W-1:0]   depth;
  logic [ROW_W-1:0]     cur_r;
  logic [COL_W-1:0]     cur_c;
  item_t                item;
  logic [2:0]           cnt;
  logic [2:0]           cap_idx;
  logic [3:0]           fresh;
  logic [3:0]           cur_walls;
  dir_t                 dir;

  logic                 tile_we;
  logic [TILE_AW-1:0]   tile_waddr, tile_raddr;
  logic [3:0]           tile_wdata, tile_rdata;
  logic                 stk_we;
  logic [STK_AW-1:0]    stk_waddr, stk_raddr;
  logic [TILE_AW-1:0]   stk_wdata, stk_rdata;

  logic                 in_range;
  logic                 stk_full;
  dir_t                 sel_dir;
  logic [ROW_W-1:0]     nb_r;
  logic [COL_W-1:0]     nb_c;
  logic [3:0]           cand;
  logic [2:0]           cand_n;
  logic [RND_W+2:0]     prod;
  logic [1:0]           pick;
  dir_t                 pick_dir;
  logic [2:0]           rank;

  mbg_ram #(.DATA_W(4), .ADDR_W(TILE_AW), .DEPTH(TILE_DEPTH)) u_tiles (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

  mbg_ram #(.DATA_W(TILE_AW), .ADDR_W(STK_AW), .DEPTH(CELL_COUNT)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_range = (CMP_W'(in_item.tile_row) < CMP_W'(rows)) &&
                    (CMP_W'(in_item.tile_col) < CMP_W'(cols));
  assign stk_full = (DEPTH_W'(CELL_COUNT) == depth);
  assign cap_idx  = cnt - 3'd1;

  // neighbour of the current cell; wraps harmlessly where the bound check rejects it
  always_comb begin
    sel_dir = (state == ST_NB) ? dir_t'(cnt[1:0]) : dir;
    nb_r    = cur_r;
    nb_c    = cur_c;
    unique case (sel_dir)
      DIR_UP:    nb_r = cur_r - ROW_W'(1);
      DIR_DOWN:  nb_r = cur_r + ROW_W'(1);
      DIR_LEFT:  nb_c = cur_c - COL_W'(1);
      DIR_RIGHT: nb_c = cur_c + COL_W'(1);
      default:   nb_r = cur_r;
    endcase
  end

  // candidate choice: rank the fresh in-bounds neighbours and take number pick
  always_comb begin
    cand[DIR_UP]    = (cur_r != '0) && fresh[DIR_UP];
    cand[DIR_DOWN]  = ((CMP_W'(cur_r) + CMP_W'(1)) < CMP_W'(rows)) && fresh[DIR_DOWN];
    cand[DIR_LEFT]  = (cur_c != '0) && fresh[DIR_LEFT];
    cand[DIR_RIGHT] = ((CMP_W'(cur_c) + CMP_W'(1)) < CMP_W'(cols)) && fresh[DIR_RIGHT];
    cand_n   = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
    prod     = (RND_W+3)'(item.rnd) * (RND_W+3)'(cand_n);
    pick     = prod[RND_W+1:RND_W];
    pick_dir = DIR_UP;
    rank     = '0;
    for (int k = 0; k < 4; k++) begin
      if (cand[k]) begin
        if (rank == {1'b0, pick}) pick_dir = dir_t'(2'(k));
        rank = rank + 3'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = clr_start ? ST_RESP : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_item.req)
            REQ_START: state_next = ST_CLEAR;
            REQ_STEP:  state_next = (depth == '0) ? ST_RESP : ST_NB;
            REQ_READ:  state_next = in_range ? ST_TILE : ST_RESP;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_TILE:   state_next = ST_RESP;
      ST_NB: begin
        if (cnt == NB_LAST) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (cand_n != '0)                 state_next = ST_WR_CUR;
        else if (depth == DEPTH_W'(1))    state_next = ST_RESP;
        else                              state_next = ST_TOP;
      end
      ST_TOP:    state_next = ST_NB;
      ST_WR_CUR: state_next = ST_WR_NB;
      ST_WR_NB:  state_next = ST_RESP;
      ST_RESP: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    res_valid  = (state == ST_RESP);
    tile_we    = 1'b0;
    tile_waddr = {cur_r, cur_c};
    tile_wdata = WALL_ALL;
    tile_raddr = (cnt == NB_SELF) ? {cur_r, cur_c} : {nb_r, nb_c};
    stk_we     = 1'b0;
    stk_waddr  = STK_AW'(depth);
    stk_wdata  = {nb_r, nb_c};
    stk_raddr  = STK_AW'(depth - DEPTH_W'(2));
    unique case (state)
      ST_CLEAR: begin
        tile_we    = 1'b1;
        tile_waddr = clr_addr;
      end
      ST_IDLE: begin
        tile_raddr = {ROW_W'(in_item.tile_row), COL_W'(in_item.tile_col)};
        if (in_valid && (in_item.req == REQ_START)) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = '0;
        end
      end
      ST_WR_CUR: begin
        tile_we    = 1'b1;
        tile_wdata = cur_walls & ~wall_bit(dir);
      end
      ST_WR_NB: begin
        tile_we    = 1'b1;
        tile_waddr = {nb_r, nb_c};
        tile_wdata = WALL_ALL & ~wall_bit(opposite(dir));
        stk_we     = !stk_full;
      end
      default: tile_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_start <= 1'b0;
      depth     <= '0;
      cur_r     <= '0;
      cur_c     <= '0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + TILE_AW'(1);
          if (clr_addr == '1) begin
            if (clr_start) begin
              depth <= DEPTH_W'(1);
              cur_r <= '0;
              cur_c <= '0;
            end
            clr_start <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            cnt  <= '0;
            res  <= '0;
            unique case (in_item.req)
              REQ_START: begin
                clr_start <= 1'b1;
                clr_addr  <= '0;
              end
              REQ_STEP: begin
                if (depth == '0) res.status <= STAT_DONE;
              end
              REQ_READ: begin
                if (!in_range) res.status <= STAT_RANGE;
              end
              default: res.status <= STAT_RANGE;
            endcase
          end
        end
        ST_TILE: begin
          res.status <= STAT_TILE;
          res.walls  <= tile_rdata;
        end
        ST_NB: begin
          cnt <= cnt + 3'd1;
          if (cnt == NB_LAST)      cur_walls <= tile_rdata;
          else if (cnt != '0)      fresh[cap_idx[1:0]] <= (tile_rdata == WALL_ALL);
        end
        ST_EVAL: begin
          if (cand_n == '0) begin
            depth <= depth - DEPTH_W'(1);
            if (depth == DEPTH_W'(1)) res.status <= STAT_DONE;
          end else begin
            dir <= pick_dir;
          end
        end
        ST_TOP: begin
          cur_r <= stk_rdata[TILE_AW-1:COL_W];
          cur_c <= stk_rdata[COL_W-1:0];
          cnt   <= '0;
        end
        ST_WR_NB: begin
          res.from_row  <= COORD_W'(cur_r);
          res.from_col  <= COORD_W'(cur_c);
          res.carve_dir <= dir;
          if (!stk_full) begin
            depth <= depth + DEPTH_W'(1);
            cur_r <= nb_r;
            cur_c <= nb_c;
          end
        end
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: tb/sv/maze_carve_checker.sv
// Checker for the maze backtracker generator: watches the request, result and size ports.
// Keeps its own copy of the grid, path stack and sizes; depends on mbg_pkg only.
module maze_carve_checker #(
  parameter int MAX_ROWS = mbg_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mbg_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [15:0]                   m_axis_tdata,
  input  logic [1:0]                    m_axis_tuser,
  input  logic                          cfg_we,
  input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbg_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbg_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;

  logic [3:0]   grid_walls [CELLS];
  int           path_cells [CELLS];
  int           path_depth;
  logic [CFG_W-1:0] row_reg;
  logic [CFG_W-1:0] col_reg;
  result_t      expected_responses [$];
  int           results_seen;

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic bit untouched(input int r, input int c);
    return grid_walls[r * MAX_COLS + c] == WALL_ALL;
  endfunction

  // Advance the grid by one request and return the response it must produce.
  function automatic result_t predict_response(input item_t it);
    result_t res;
    dir_t    cand [4];
    dir_t    d;
    int      rows, cols, r, c, nr, nc, n, pick;
    bit      carved;
    res    = '0;
    carved = 1'b0;
    rows   = clamp_size(row_reg, MAX_ROWS);
    cols   = clamp_size(col_reg, MAX_COLS);
    case (it.req)
      REQ_START: begin
        foreach (grid_walls[k]) grid_walls[k] = WALL_ALL;
        path_cells[0] = 0;
        path_depth    = 1;
        res.status    = STAT_CARVED;
      end
      REQ_READ: begin
        if (int'(it.tile_row) >= rows || int'(it.tile_col) >= cols) begin
          res.status = STAT_RANGE;
        end else begin
          res.status = STAT_TILE;
          res.walls  = grid_walls[int'(it.tile_row) * MAX_COLS + int'(it.tile_col)];
        end
      end
      REQ_NONE: res.status = STAT_RANGE;
      default: begin
        res.status = STAT_DONE;
        while (path_depth > 0 && !carved) begin
          r = path_cells[path_depth - 1] / MAX_COLS;
          c = path_cells[path_depth - 1] % MAX_COLS;
          n = 0;
          if (r > 0 && untouched(r - 1, c)) begin cand[n] = DIR_UP; n++; end
          if (r + 1 < rows && untouched(r + 1, c)) begin cand[n] = DIR_DOWN; n++; end
          if (c > 0 && untouched(r, c - 1)) begin cand[n] = DIR_LEFT; n++; end
          if (c + 1 < cols && untouched(r, c + 1)) begin cand[n] = DIR_RIGHT; n++; end
          if (n == 0) begin
            path_depth--;
          end else begin
            pick = (int'(it.rnd) * n) >> 16;
            d    = cand[pick];
            nr   = r;
            nc   = c;
            case (d)
              DIR_UP: begin
                nr = r - 1;
                grid_walls[r * MAX_COLS + c][DIR_UP]     = 1'b0;
                grid_walls[nr * MAX_COLS + nc][DIR_DOWN] = 1'b0;
              end
              DIR_DOWN: begin
                nr = r + 1;
                grid_walls[r * MAX_COLS + c][DIR_DOWN]   = 1'b0;
                grid_walls[nr * MAX_COLS + nc][DIR_UP]   = 1'b0;
              end
              DIR_LEFT: begin
                nc = c - 1;
                grid_walls[r * MAX_COLS + c][DIR_LEFT]    = 1'b0;
                grid_walls[nr * MAX_COLS + nc][DIR_RIGHT] = 1'b0;
              end
              default: begin
                nc = c + 1;
                grid_walls[r * MAX_COLS + c][DIR_RIGHT]  = 1'b0;
                grid_walls[nr * MAX_COLS + nc][DIR_LEFT] = 1'b0;
              end
            endcase
            // a full stack keeps the carve but drops the push
            if (path_depth < CELLS) begin
              path_cells[path_depth] = nr * MAX_COLS + nc;
              path_depth++;
            end
            res.status    = STAT_CARVED;
            res.from_row  = r[COORD_W-1:0];
            res.from_col  = c[COORD_W-1:0];
            res.carve_dir = d;
            carved        = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch in result %0d, %s: expected %0d, got %0d",
                 results_seen, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    item_t   req;
    result_t want;
    result_t got;
    if (rst) begin
      foreach (grid_walls[k]) grid_walls[k] = WALL_ALL;
      path_depth = 0;
      row_reg    = CFG_SIZE_RESET;
      col_reg    = CFG_SIZE_RESET;
      expected_responses.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROW_COUNT) row_reg = cfg_data;
        else col_reg = cfg_data;
      end
      // compare first so a stray result never meets the expectation pushed this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = stat_t'(m_axis_tuser);
        got.from_row  = m_axis_tdata[4:0];
        got.from_col  = m_axis_tdata[9:5];
        got.carve_dir = dir_t'(m_axis_tdata[11:10]);
        got.walls     = m_axis_tdata[15:12];
        if (expected_responses.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: status %0d data 0x%04h",
                     results_seen, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          check_field("status", want.status, got.status);
          check_field("from_row", want.from_row, got.from_row);
          check_field("from_col", want.from_col, got.from_col);
          check_field("carve_dir", want.carve_dir, got.carve_dir);
          check_field("walls", want.walls, got.walls);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.req      = req_t'(s_axis_tuser);
        req.rnd      = s_axis_tdata[15:0];
        req.tile_row = s_axis_tdata[20:16];
        req.tile_col = s_axis_tdata[25:21];
        expected_responses.push_back(predict_response(req));
      end
    end
    outstanding = expected_responses.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top-level testbench of the maze backtracker generator: clock, reset, stimulus, verdict.
// Depends on mbg_pkg, maze_backtracker_generator and maze_carve_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbg_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // random_value, tile_row, tile_col
  logic [1:0]           s_axis_tuser = '0;   // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // from_row, from_col, carve_dir, walls up..right
  logic [1:0]           m_axis_tuser;        // status
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  int beats_sent = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  // size in use after clamping, kept to aim reads and size the carve runs
  int grid_rows = DEF_MAX_ROWS;
  int grid_cols = DEF_MAX_COLS;

  always #6 clk = ~clk;

  maze_backtracker_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  maze_carve_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Stall the result side at random; the rate follows the current phase.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung block: reset sweep, every start sweep and every
  // backtrack under heavy stalls stay far below this.
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int clamp_size(input int v);
    if (v < 1) return 1;
    if (v > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return v;
  endfunction

  // Mostly uniform words, with the two ends of the range showing up often.
  function automatic logic [RND_W-1:0] random_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return RND_W'($urandom_range(65535));
  endfunction

  // Present one request beat and hold it until the block takes it.
  // Valid stays high into the next call, which either replaces the data or idles.
  task automatic send_beat(input req_t req, input logic [RND_W-1:0] rnd,
                           input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'd0, col, row, rnd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write both size registers while the block is idle.
  task automatic set_size(input int rows_raw, input int cols_raw);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= CFG_W'(rows_raw);
    @(negedge clk);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= CFG_W'(cols_raw);
    @(negedge clk);
    cfg_we    <= 1'b0;
    grid_rows = clamp_size(rows_raw & 63);
    grid_cols = clamp_size(cols_raw & 63);
  endtask

  // Read one tile: mostly inside the grid in use, the rest anywhere in the field range.
  task automatic read_tile();
    if ($urandom_range(99) < 70)
      send_beat(REQ_READ, random_word(), COORD_W'($urandom_range(grid_rows - 1)),
                COORD_W'($urandom_range(grid_cols - 1)));
    else
      send_beat(REQ_READ, random_word(), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // Generate mazes of random sizes: each run starts, then sends a budget of carve steps
  // (capped for big grids) with reads, stray codes, restarts, drains and resizes mixed
  // in, then reads a few tiles of the result.
  task automatic carve_random_mazes(input int quota);
    int stop_at, roll, steps, k, rows_raw, cols_raw;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        rows_raw = $urandom_range(2, 5);
        cols_raw = $urandom_range(2, 5);
      end else if (roll < 72) begin
        rows_raw = $urandom_range(1, 8);
        cols_raw = $urandom_range(1, 8);
      end else if (roll < 82) begin
        rows_raw = $urandom_range(1) ? DEF_MAX_ROWS : 1;
        cols_raw = $urandom_range(1) ? DEF_MAX_COLS : 1;
      end else if (roll < 92) begin
        // out-of-range register values clamp to one or to the grid limit
        rows_raw = $urandom_range(1) ? 0 : $urandom_range(33, 63);
        cols_raw = $urandom_range(1) ? $urandom_range(2, 4) : 0;
      end else begin
        rows_raw = $urandom_range(9, 32);
        cols_raw = $urandom_range(9, 32);
      end
      set_size(rows_raw, cols_raw);
      steps = grid_rows * grid_cols + 3;
      if (steps > 60) steps = 60;
      send_beat(REQ_START, random_word(), COORD_W'($urandom), COORD_W'($urandom));
      for (k = 0; k < steps && beats_sent < stop_at; k++) begin
        roll = $urandom_range(99);
        if (roll < 74)
          send_beat(REQ_STEP, random_word(), COORD_W'($urandom), COORD_W'($urandom));
        else if (roll < 90)
          read_tile();
        else if (roll < 93)
          send_beat(REQ_NONE, random_word(), COORD_W'($urandom), COORD_W'($urandom));
        else if (roll < 95)
          send_beat(REQ_START, random_word(), COORD_W'($urandom), COORD_W'($urandom));
        else if (roll < 97)
          drain();
        else
          // shrink or grow the bounds while cells sit on the stack
          set_size($urandom_range(1, 8), $urandom_range(1, 8));
      end
      repeat ($urandom_range(1, 3)) read_tile();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 23;
    recv_idle_pct   = 85;

    // Directed: full default grid. A step before any start finds an empty stack.
    send_beat(REQ_STEP, '1, '0, '0);
    send_beat(REQ_READ, '0, '0, '0);
    send_beat(REQ_READ, '1, '1, '1);
    send_beat(REQ_NONE, '1, '1, '1);
    send_beat(REQ_START, '0, '0, '0);
    send_beat(REQ_STEP, '0, '0, '0);
    send_beat(REQ_STEP, '1, '0, '0);
    send_beat(REQ_STEP, 16'h8000, '0, '0);
    send_beat(REQ_READ, '0, '0, '0);
    send_beat(REQ_READ, '0, 5'd1, '0);

    // Single tile: the first step already finishes; anything past it is out of range.
    set_size(1, 1);
    send_beat(REQ_START, '0, '0, '0);
    send_beat(REQ_STEP, '1, '0, '0);
    send_beat(REQ_READ, '0, '0, '0);
    send_beat(REQ_READ, '0, '0, 5'd1);
    send_beat(REQ_READ, '0, 5'd1, '0);

    // Zero rows clamps to one, 63 columns clamps to the grid limit.
    set_size(0, 63);
    send_beat(REQ_START, '0, '0, '0);
    send_beat(REQ_STEP, '1, '0, '0);
    send_beat(REQ_READ, '0, '0, 5'd31);
    send_beat(REQ_READ, '0, 5'd1, '0);

    // Smallest full maze, run to completion and one step beyond.
    set_size(2, 2);
    send_beat(REQ_START, '0, '0, '0);
    repeat (4) send_beat(REQ_STEP, random_word(), '0, '0);
    send_beat(REQ_STEP, random_word(), '0, '0);
    send_beat(REQ_READ, '0, 5'd1, 5'd1);

    carve_random_mazes(210);

    drain();
    sender_idle_pct = 85;
    recv_idle_pct   = 23;
    carve_random_mazes(210);

    drain();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    carve_random_mazes(205);

    drain();
    // Let any late or stray result show up; a start sweep is the longest item.
    repeat (1100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
